// ----- design/dqls_pkg.sv -----
// shared types and constants of the query likelihood scorer
// no dependencies
package dqls_pkg;

  // fraction bits of the score
  localparam int unsigned FRAC_BITS = 16;
  // fraction bits of each base-2 logarithm
  localparam int unsigned LOG_FRAC  = FRAC_BITS + 6;
  // integer part of a logarithm: exponent 0..64
  localparam int unsigned EXP_W     = 7;
  localparam int unsigned LOG_W     = EXP_W + LOG_FRAC;
  // signed log difference
  localparam int unsigned DIFF_W    = LOG_W + 2;
  localparam int unsigned ITER_W    = $clog2(LOG_FRAC);
  // ln 2 in Q24
  localparam int unsigned LN2_W     = 24;
  localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
  localparam int unsigned RND_SH    = LOG_FRAC + 24 - FRAC_BITS;
  localparam int unsigned PROD_W    = DIFF_W - 1 + LN2_W;
  localparam int unsigned TERM_W    = PROD_W + 1 - RND_SH;
  localparam int unsigned SUM_W     = ((TERM_W > 32) ? TERM_W : 32) + 2;

  // field widths
  localparam int unsigned TF_W   = 24;
  localparam int unsigned CF_W   = 40;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned MU_W   = 16;
  localparam int unsigned CS_W   = 40;
  localparam int unsigned NUM_W  = 65;
  localparam int unsigned DEN_W  = 25;
  localparam int unsigned SCORE_W = 32;

  localparam logic [MU_W-1:0] MU_RESET = 16'd2500;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MU    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD = 2'd2;

  // one prepared term between front and back
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [CS_W-1:0]  csize;
    logic             last;
  } term_t;

endpackage

// ----- design/dqls_front.sv -----
// front end: accepts a term word and forms the smoothed count tf*C + mu*cf
// depends on dqls_pkg
module dqls_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dqls_pkg::TF_W-1:0]   term_freq_i,
  input  logic [dqls_pkg::CF_W-1:0]   coll_freq_i,
  input  logic [dqls_pkg::LEN_W-1:0]  passage_length_i,
  input  logic                        last_term_i,
  input  logic [dqls_pkg::MU_W-1:0]   mu_i,
  input  logic [dqls_pkg::CS_W-1:0]   csize_i,
  input  logic                        guard_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output dqls_pkg::term_t             q_word_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PUSH} state_e;

  state_e                       state_q;
  logic [1:0]                   step_q;
  logic [dqls_pkg::TF_W-1:0]    tf_q;
  logic [dqls_pkg::CF_W-1:0]    cf_q;
  logic [dqls_pkg::CS_W-1:0]    c_q;
  logic [dqls_pkg::MU_W-1:0]    m_q;
  logic [dqls_pkg::DEN_W-1:0]   den_q;
  logic                         last_q;
  logic [dqls_pkg::NUM_W-1:0]   acc_q, acc_d;

  logic [23:0] mul_a;
  logic [19:0] mul_b;
  logic [43:0] prod;
  logic [dqls_pkg::NUM_W-1:0] addend;
  logic [dqls_pkg::MU_W-1:0]  m_eff;

  assign m_eff = (mu_i == '0) ? dqls_pkg::MU_W'(1) : mu_i;

  // shared 24x20 multiplier, four partial products
  always_comb begin
    case (step_q)
      2'd0: begin mul_a = tf_q;          mul_b = c_q[19:0];   end
      2'd1: begin mul_a = tf_q;          mul_b = c_q[39:20];  end
      2'd2: begin mul_a = {8'd0, m_q};   mul_b = cf_q[19:0];  end
      default: begin mul_a = {8'd0, m_q}; mul_b = cf_q[39:20]; end
    endcase
    prod   = mul_a * mul_b;
    addend = step_q[0] ? {1'b0, prod, 20'd0} : {21'd0, prod};
    acc_d  = acc_q + addend;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign q_valid_o  = (state_q == S_PUSH);
  assign q_word_o   = '{num: acc_q, den: den_q, csize: c_q, last: last_q};

  // sequencer and operand registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      tf_q    <= '0;
      cf_q    <= '0;
      c_q     <= '0;
      m_q     <= '0;
      den_q   <= '0;
      last_q  <= 1'b0;
      acc_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tf_q <= term_freq_i;
            cf_q <= (guard_i && term_freq_i == '0 && coll_freq_i == '0)
                    ? dqls_pkg::CF_W'(1) : coll_freq_i;
            c_q  <= (csize_i == '0) ? dqls_pkg::CS_W'(1) : csize_i;
            m_q  <= m_eff;
            den_q <= dqls_pkg::DEN_W'(passage_length_i) + dqls_pkg::DEN_W'(m_eff);
            last_q <= last_term_i;
            acc_q  <= '0;
            step_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          acc_q  <= acc_d;
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (q_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/dqls_queue.sv -----
// two-entry queue of prepared term words between front and back
// depends on dqls_pkg
module dqls_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  dqls_pkg::term_t wr_word_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output dqls_pkg::term_t rd_word_o
);

  dqls_pkg::term_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_word_o  = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_word_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ----- design/dqls_back.sv -----
// back end: three iterative logarithms, ln 2 scaling, saturated running sum
// depends on dqls_pkg
module dqls_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  dqls_pkg::term_t                q_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [dqls_pkg::SCORE_W-1:0] score_o,
  output logic                           minus_infinity_o,
  output logic                           saturated_o
);

  localparam int unsigned NW = dqls_pkg::NUM_W;
  localparam int unsigned GW = dqls_pkg::LOG_FRAC;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_NORM, B_SQ, B_LOGD, B_MUL, B_ACC, B_DONE
  } state_e;

  state_e                             state_q;
  dqls_pkg::term_t                    word_q;
  logic [1:0]                         op_q;
  logic [NW-1:0]                      v_q;
  logic [dqls_pkg::EXP_W-1:0]         sh_q;
  logic [31:0]                        m_q;
  logic [GW-1:0]                      frac_q;
  logic [dqls_pkg::ITER_W-1:0]        it_q;
  logic signed [dqls_pkg::DIFF_W-1:0] d_q;
  logic [dqls_pkg::PROD_W-1:0]        prod_q;
  logic signed [31:0]                 run_q;
  logic                               inf_q, sat_q;
  logic                               out_valid_q, out_inf_q, out_sat_q;
  logic signed [31:0]                 out_score_q;

  logic [63:0]                        sq;
  logic [32:0]                        sq_t;
  logic signed [dqls_pkg::DIFF_W-1:0] lg;
  logic [dqls_pkg::DIFF_W-2:0]        mag;
  logic [dqls_pkg::PROD_W:0]          rnd;
  logic [dqls_pkg::TERM_W-1:0]        term;
  logic signed [dqls_pkg::SUM_W-1:0]  sum;
  logic signed [dqls_pkg::SUM_W-1:0]  sum_max, sum_min;
  logic                               emit;

  // squaring step of the log fraction
  always_comb begin
    sq   = m_q * m_q;
    sq_t = sq[63:31];
  end

  // log value of the current operand and the signed difference
  always_comb begin
    lg  = dqls_pkg::DIFF_W'({dqls_pkg::EXP_W'(64) - sh_q, frac_q});
    mag = d_q[dqls_pkg::DIFF_W-1] ? (dqls_pkg::DIFF_W-1)'(-d_q)
                                  : (dqls_pkg::DIFF_W-1)'(d_q);
  end

  // rounding and saturated accumulation
  always_comb begin
    rnd     = {1'b0, prod_q} + ((dqls_pkg::PROD_W+1)'(1) << (dqls_pkg::RND_SH - 1));
    term    = dqls_pkg::TERM_W'(rnd >> dqls_pkg::RND_SH);
    sum_max = dqls_pkg::SUM_W'(32'sh7fffffff);
    sum_min = -sum_max - dqls_pkg::SUM_W'(1);
    if (d_q[dqls_pkg::DIFF_W-1])
      sum = dqls_pkg::SUM_W'(run_q) - $signed({2'b00, term});
    else
      sum = dqls_pkg::SUM_W'(run_q) + $signed({2'b00, term});
  end

  // result word goes out at the end of a last term once the register is free
  assign emit = (state_q == B_DONE) && word_q.last && (!out_valid_q || out_ready_i);

  assign q_ready_o        = (state_q == B_IDLE);
  assign out_valid_o      = out_valid_q;
  assign score_o          = out_score_q;
  assign minus_infinity_o = out_inf_q;
  assign saturated_o      = out_sat_q;

  // sequencer, log unit, accumulator and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      word_q      <= '0;
      op_q        <= '0;
      v_q         <= '0;
      sh_q        <= '0;
      m_q         <= '0;
      frac_q      <= '0;
      it_q        <= '0;
      d_q         <= '0;
      prod_q      <= '0;
      run_q       <= '0;
      inf_q       <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_inf_q   <= 1'b0;
      out_sat_q   <= 1'b0;
      out_score_q <= '0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            word_q <= q_word_i;
            op_q   <= '0;
            d_q    <= '0;
            if (q_word_i.num == '0) begin
              inf_q   <= 1'b1;
              state_q <= B_DONE;
            end else begin
              state_q <= B_LOAD;
            end
          end
        end
        B_LOAD: begin
          case (op_q)
            2'd0:    v_q <= word_q.num;
            2'd1:    v_q <= NW'(word_q.csize);
            default: v_q <= NW'(word_q.den);
          endcase
          sh_q    <= '0;
          state_q <= B_NORM;
        end
        B_NORM: begin
          if (v_q[NW-1]) begin
            m_q     <= v_q[NW-1:NW-32];
            frac_q  <= '0;
            it_q    <= '0;
            state_q <= B_SQ;
          end else if (v_q[NW-1:NW-8] == '0) begin
            v_q  <= v_q << 8;
            sh_q <= sh_q + dqls_pkg::EXP_W'(8);
          end else begin
            v_q  <= v_q << 1;
            sh_q <= sh_q + dqls_pkg::EXP_W'(1);
          end
        end
        B_SQ: begin
          if (sq_t[32]) begin
            m_q    <= sq_t[32:1];
            frac_q <= {frac_q[GW-2:0], 1'b1};
          end else begin
            m_q    <= sq_t[31:0];
            frac_q <= {frac_q[GW-2:0], 1'b0};
          end
          it_q <= it_q + dqls_pkg::ITER_W'(1);
          if (it_q == dqls_pkg::ITER_W'(GW - 1)) state_q <= B_LOGD;
        end
        B_LOGD: begin
          d_q  <= (op_q == 2'd0) ? d_q + lg : d_q - lg;
          op_q <= op_q + 2'd1;
          state_q <= (op_q == 2'd2) ? B_MUL : B_LOAD;
        end
        B_MUL: begin
          prod_q  <= mag * dqls_pkg::LN2_Q24;
          state_q <= B_ACC;
        end
        B_ACC: begin
          if (sum > sum_max) begin
            run_q <= 32'sh7fffffff;
            sat_q <= 1'b1;
          end else if (sum < sum_min) begin
            run_q <= 32'sh80000000;
            sat_q <= 1'b1;
          end else begin
            run_q <= 32'(sum);
          end
          state_q <= B_DONE;
        end
        B_DONE: begin
          if (!word_q.last) begin
            state_q <= B_IDLE;
          end else if (emit) begin
            out_score_q <= inf_q ? 32'sh80000000 : run_q;
            out_inf_q   <= inf_q;
            out_sat_q   <= sat_q;
            run_q       <= '0;
            inf_q       <= 1'b0;
            sat_q       <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // the log unit only squares a normalized mantissa
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SQ) |-> m_q[31])
    else $error("mantissa not normalized");

  // normalization never runs on a zero operand
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_NORM) |-> (v_q != '0))
    else $error("normalizing zero operand");

  // an infinite result always carries the most negative score
  a_inf_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_inf_q) |-> (out_score_q == 32'sh80000000))
    else $error("minus infinity with finite score");

  // a new word is taken only with the sequencer idle
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_ready_o) |=> (state_q != B_IDLE))
    else $error("word taken without starting work");

endmodule

// ----- design/dirichlet_query_likelihood_score_top.sv -----
// top level of the Dirichlet-smoothed query likelihood scorer
// depends on dqls_pkg, dqls_front, dqls_queue, dqls_back
//
// Each input word is one query term: term_freq, coll_freq, passage_length
// and last_term, taken on in_valid_i & in_ready_o. Every term adds
// ln((tf + mu*cf/C) / (len + mu)) to a running sum in signed Q16.16; the
// term marked last produces one output word (score, minus_infinity,
// saturated) on out_valid_o & out_ready_i and clears the sum.
// The front takes a word, runs four passes of a shared 24x20 multiplier
// and pushes the result into a two-entry queue, waiting while it is full.
// The back sets the pace: it takes the word; for each of three base-2 logs
// it loads and normalizes the operand, runs the squaring steps on a 32x32
// multiplier and adds the log in; then it does ln 2 scaling, accumulation
// and the end of the term (a zero count goes straight there). Neither end
// takes a new term while busy. Configuration: cfg_we_i writes register
// cfg_index_i (0 mu, 1 collection size, 2 zero guard); the user must write
// only while the block is idle, which the block itself does not enforce.
// Reset restores mu 2500, collection size 1, zero guard 1 and clears the
// sum. A stalled receiver holds the result word; the back then waits on
// the next last term; the queue and front keep taking terms until it fills.
module dirichlet_query_likelihood_score_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dqls_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [dqls_pkg::CS_W-1:0]               cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [dqls_pkg::TF_W-1:0]               term_freq_i,
  input  logic [dqls_pkg::CF_W-1:0]               coll_freq_i,
  input  logic [dqls_pkg::LEN_W-1:0]              passage_length_i,
  input  logic                                    last_term_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [dqls_pkg::SCORE_W-1:0]     score_o,
  output logic                                    minus_infinity_o,
  output logic                                    saturated_o
);

  logic [dqls_pkg::MU_W-1:0] mu_q;
  logic [dqls_pkg::CS_W-1:0] csize_q;
  logic                      guard_q;

  logic            fq_valid, fq_ready, qb_valid, qb_ready;
  dqls_pkg::term_t fq_word, qb_word;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q    <= dqls_pkg::MU_RESET;
      csize_q <= dqls_pkg::CS_W'(1);
      guard_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dqls_pkg::REG_MU:    mu_q    <= cfg_data_i[dqls_pkg::MU_W-1:0];
        dqls_pkg::REG_CSIZE: csize_q <= cfg_data_i;
        dqls_pkg::REG_GUARD: guard_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dqls_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .term_freq_i, .coll_freq_i, .passage_length_i, .last_term_i,
    .mu_i(mu_q), .csize_i(csize_q), .guard_i(guard_q),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_word_o(fq_word)
  );

  dqls_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_word_i(fq_word),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_word_o(qb_word)
  );

  dqls_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qb_valid), .q_ready_o(qb_ready), .q_word_i(qb_word),
    .out_valid_o, .out_ready_i,
    .score_o, .minus_infinity_o, .saturated_o
  );

endmodule
